[rtl/core/pfa_pkg.sv]
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared constants, codes and types for the partition fit allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package pfa_pkg;

   // Table geometry
   localparam int PARTITIONS = 16;
   localparam int SIZE_BITS  = 16;
   localparam int IDX_W      = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
   localparam int CTR_W      = IDX_W + 1;
   localparam int CMP_W      = IDX_W + 6;

   // Field widths
   localparam int ACTION_W = 1;
   localparam int POLICY_W = 2;
   localparam int SLOT_W   = 4;
   localparam int AMOUNT_W = 16;
   localparam int STATUS_W = 2;
   localparam int REMAIN_W = 16;
   localparam int TOTAL_W  = 20;
   localparam int COUNT_W  = 5;

   // Compare width that holds both a size and a requested amount
   localparam int VAL_W = (SIZE_BITS > AMOUNT_W) ? SIZE_BITS : AMOUNT_W;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;

   // Request kinds
   localparam logic [ACTION_W-1:0] ACT_LOAD  = 1'b0;
   localparam logic [ACTION_W-1:0] ACT_ALLOC = 1'b1;

   // Fit policies
   localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
   localparam logic [POLICY_W-1:0] POL_WORST = 2'd1;
   localparam logic [POLICY_W-1:0] POL_BEST  = 2'd2;

   // Response status codes
   localparam logic [STATUS_W-1:0] STS_LOADED    = 2'd0;
   localparam logic [STATUS_W-1:0] STS_ALLOCATED = 2'd1;
   localparam logic [STATUS_W-1:0] STS_REFUSED   = 2'd2;

   // One table entry as it comes out of the read port
   typedef struct packed {
      logic                 valid;
      logic [IDX_W-1:0]     idx;
      logic [SIZE_BITS-1:0] value;
   } entry_type;

   // Request held for the duration of a scan
   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [POLICY_W-1:0] policy;
      logic [SLOT_W-1:0]   slot;
      logic [AMOUNT_W-1:0] amount;
   } ctx_type;

   // Outcome of a scan
   typedef struct packed {
      logic                 found;
      logic [IDX_W-1:0]     idx;
      logic [SIZE_BITS-1:0] value;
      logic [TOTAL_W-1:0]   sum;
   } pick_type;

   // True when a load slot lands inside the table
   function automatic logic slot_in_table(input logic [SLOT_W-1:0] slot);
      return CMP_W'(slot) < CMP_W'(PARTITIONS);
   endfunction

endpackage

`default_nettype wire

[rtl/core/pfa_table.sv]
// ----------------------------------------------------------------------------
// pfa_table
// Partition free-size memory: one write and one registered read per cycle,
// with a valid bit per entry so unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module pfa_table (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          rd_en,
   input  wire logic [pfa_pkg::IDX_W-1:0]     rd_addr,
   input  wire logic                          wr_en,
   input  wire logic [pfa_pkg::IDX_W-1:0]     wr_addr,
   input  wire logic [pfa_pkg::SIZE_BITS-1:0] wr_data,
   output pfa_pkg::entry_type                 rd_entry
);

   logic [pfa_pkg::SIZE_BITS-1:0]  mem_ff [pfa_pkg::PARTITIONS];
   logic [pfa_pkg::PARTITIONS-1:0] valid_ff;
   logic [pfa_pkg::SIZE_BITS-1:0]  rd_data_ff;
   logic                           rd_vld_ff;
   logic [pfa_pkg::IDX_W-1:0]      rd_idx_ff;
   logic                           rd_en_ff;

   // Storage array and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
         rd_vld_ff  <= valid_ff[rd_addr];
         rd_idx_ff  <= rd_addr;
      end
   end

   // Entry valid bits and read strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         rd_en_ff <= 1'b0;
      end else begin
         rd_en_ff <= rd_en;
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   // Never-written entries read as zero
   assign rd_entry.valid = rd_en_ff;
   assign rd_entry.idx   = rd_idx_ff;
   assign rd_entry.value = rd_vld_ff ? rd_data_ff : '0;

endmodule

`default_nettype wire

[rtl/core/pfa_select.sv]
// ----------------------------------------------------------------------------
// pfa_select
// Scan accumulator: takes one table entry per cycle, keeps the running free
// total over the partitions in use and the candidate for the fit policy.
// ----------------------------------------------------------------------------
`default_nettype none

module pfa_select (
   input  wire logic                        clock,
   input  wire logic                        start,
   input  wire pfa_pkg::ctx_type            ctx,
   input  wire logic [pfa_pkg::COUNT_W-1:0] count,
   input  wire pfa_pkg::entry_type          entry,
   output pfa_pkg::pick_type                pick
);

   logic                          hit_ff;
   logic                          any_ff;
   logic [pfa_pkg::IDX_W-1:0]     idx_ff;
   logic [pfa_pkg::SIZE_BITS-1:0] val_ff;
   logic [pfa_pkg::TOTAL_W-1:0]   sum_ff;

   logic                          in_use;
   logic                          fwd;
   logic [pfa_pkg::SIZE_BITS-1:0] val;
   logic [pfa_pkg::VAL_W-1:0]     req;
   logic                          fits;
   logic                          take;

   // Entry in use, with a pending load forwarded into the total
   always_comb begin
      in_use = entry.valid &&
               (pfa_pkg::CMP_W'(entry.idx) < pfa_pkg::CMP_W'(count));
      fwd    = (ctx.action == pfa_pkg::ACT_LOAD) && pfa_pkg::slot_in_table(ctx.slot) &&
               (pfa_pkg::CMP_W'(ctx.slot) == pfa_pkg::CMP_W'(entry.idx));
      val    = fwd ? pfa_pkg::SIZE_BITS'(ctx.amount) : entry.value;
      req    = pfa_pkg::VAL_W'(ctx.amount);
      fits   = pfa_pkg::VAL_W'(val) >= req;
   end

   // Candidate update per policy
   always_comb begin
      case (ctx.policy)
         pfa_pkg::POL_FIRST: take = fits && !hit_ff;
         pfa_pkg::POL_WORST: take = val > val_ff;
         pfa_pkg::POL_BEST:  take = fits && (!hit_ff || (val < val_ff));
         default:            take = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (start) begin
         hit_ff <= 1'b0;
         any_ff <= 1'b0;
         idx_ff <= '0;
         val_ff <= '0;
         sum_ff <= '0;
      end else if (in_use) begin
         any_ff <= 1'b1;
         sum_ff <= sum_ff + pfa_pkg::TOTAL_W'(val);
         if (take) begin
            hit_ff <= 1'b1;
            idx_ff <= entry.idx;
            val_ff <= val;
         end
      end
   end

   // Final verdict; worst fit checks the largest size against the request
   always_comb begin
      case (ctx.policy) inside
         pfa_pkg::POL_FIRST, pfa_pkg::POL_BEST: pick.found = hit_ff;
         pfa_pkg::POL_WORST: pick.found = any_ff && (pfa_pkg::VAL_W'(val_ff) >= req);
         default:            pick.found = 1'b0;
      endcase
      pick.idx   = idx_ff;
      pick.value = val_ff;
      pick.sum   = sum_ff;
   end

endmodule

`default_nettype wire

[rtl/core/partition_fit_allocator_core.sv]
// ----------------------------------------------------------------------------
// partition_fit_allocator_core
// First/worst/best fit partition allocator over a free-size table in memory.
//
//   Channel  Direction  Signals                         Contents
//   req      in         req_tvalid/tready/tdata/tuser   load or allocate
//   rsp      out        rsp_tvalid/tready/tdata/tuser   status, slot, totals
//   csr      in         csr_wr_en/csr_wr_data           partition_count
//
// Each request steps through ST_IDLE, which accepts it, ST_SCAN, which
// streams every entry through the single read port of the table, and ST_DONE,
// which writes the entry back and registers the response.
// Reset clears the table valid bits at once; no clearing pass is needed.
// The response sits in an output register; a stalled rsp side holds only
// the write-back step, and the next request is taken once it completes.
// ----------------------------------------------------------------------------
`default_nettype none

module partition_fit_allocator_core (
   input  wire logic        clock,
   input  wire logic        reset,
   // csr: partition_count
   input  wire logic        csr_wr_en,
   input  wire logic [4:0]  csr_wr_data,
   // req
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [23:0] req_tdata,   // slot[3:0], amount[19:4], zero[23:20]
   input  wire logic [2:0]  req_tuser,   // action[0], fit_policy[2:1]
   // rsp
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [39:0] rsp_tdata,   // slot_used[3:0], slot_remaining[19:4],
                                         // total_free[39:20]
   output      logic [1:0]  rsp_tuser    // status[1:0]
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type                     state_ff, state_in;
   logic [pfa_pkg::COUNT_W-1:0]   count_ff;
   pfa_pkg::ctx_type              ctx_ff;
   logic [pfa_pkg::CTR_W-1:0]     rd_ctr_ff, rd_ctr_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [pfa_pkg::STATUS_W-1:0]  status_ff, status_in;
   logic [pfa_pkg::SLOT_W-1:0]    used_ff, used_in;
   logic [pfa_pkg::REMAIN_W-1:0]  remain_ff, remain_in;
   logic [pfa_pkg::TOTAL_W-1:0]   total_ff, total_in;

   logic                          accept;
   logic                          rd_en;
   logic                          scan_end;
   logic                          fire;
   logic                          wr_en;
   logic [pfa_pkg::IDX_W-1:0]     wr_addr;
   logic [pfa_pkg::SIZE_BITS-1:0] wr_data;
   logic [pfa_pkg::SIZE_BITS-1:0] new_val;
   pfa_pkg::entry_type            entry;
   pfa_pkg::pick_type             pick;

   // Handshake
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rd_en      = (state_ff == ST_SCAN) &&
                       (rd_ctr_ff < pfa_pkg::CTR_W'(pfa_pkg::PARTITIONS));
   assign scan_end   = (state_ff == ST_SCAN) &&
                       (rd_ctr_ff == pfa_pkg::CTR_W'(pfa_pkg::PARTITIONS));
   assign fire       = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      rd_ctr_in = rd_ctr_ff;
      unique case (state_ff)
         ST_IDLE: begin
            rd_ctr_in = '0;
            if (accept) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (rd_en) begin
               rd_ctr_in = rd_ctr_ff + pfa_pkg::CTR_W'(1);
            end
            if (scan_end) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (fire) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Write-back and response for the finished scan
   always_comb begin
      new_val   = pfa_pkg::SIZE_BITS'(pfa_pkg::VAL_W'(pick.value) -
                                      pfa_pkg::VAL_W'(ctx_ff.amount));
      wr_en     = 1'b0;
      wr_addr   = pfa_pkg::IDX_W'(ctx_ff.slot);
      wr_data   = pfa_pkg::SIZE_BITS'(ctx_ff.amount);
      status_in = status_ff;
      used_in   = used_ff;
      remain_in = remain_ff;
      total_in  = total_ff;
      if (fire) begin
         total_in = pick.sum;
         if (ctx_ff.action == pfa_pkg::ACT_LOAD) begin
            status_in = pfa_pkg::STS_LOADED;
            used_in   = ctx_ff.slot;
            remain_in = '0;
            if (pfa_pkg::slot_in_table(ctx_ff.slot)) begin
               wr_en     = 1'b1;
               remain_in = pfa_pkg::REMAIN_W'(wr_data);
            end
         end else if (pick.found) begin
            wr_en     = 1'b1;
            wr_addr   = pick.idx;
            wr_data   = new_val;
            status_in = pfa_pkg::STS_ALLOCATED;
            used_in   = pfa_pkg::SLOT_W'(pick.idx);
            remain_in = pfa_pkg::REMAIN_W'(new_val);
            total_in  = pick.sum - pfa_pkg::TOTAL_W'(ctx_ff.amount);
         end else begin
            status_in = pfa_pkg::STS_REFUSED;
            used_in   = '0;
            remain_in = '0;
         end
      end
   end

   // Output valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= pfa_pkg::COUNT_RESET;
         rd_ctr_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_ctr_ff    <= rd_ctr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            count_ff <= csr_wr_data;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         ctx_ff.action <= req_tuser[0];
         ctx_ff.policy <= req_tuser[2:1];
         ctx_ff.slot   <= req_tdata[3:0];
         ctx_ff.amount <= req_tdata[19:4];
      end
      status_ff <= status_in;
      used_ff   <= used_in;
      remain_ff <= remain_in;
      total_ff  <= total_in;
   end

   pfa_table u_table (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (rd_en),
      .rd_addr  (rd_ctr_ff[pfa_pkg::IDX_W-1:0]),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_entry (entry)
   );

   pfa_select u_select (
      .clock (clock),
      .start (accept),
      .ctx   (ctx_ff),
      .count (count_ff),
      .entry (entry),
      .pick  (pick)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = {total_ff, remain_ff, used_ff};

endmodule

`default_nettype wire

[rtl/core/pfa_checker.sv]
// ----------------------------------------------------------------------------
// pfa_checker
// Port-level checks for the partition fit allocator, bound to the core.
// ----------------------------------------------------------------------------
`default_nettype none

module pfa_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [39:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser
);

   // Nothing is presented right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // One request at a time: the input closes after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while scan in progress");

   // A stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) &&
                                       $stable(rsp_tuser)))
      else $error("stalled response changed");

   // Status is a known code
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == pfa_pkg::STS_LOADED ||
                      rsp_tuser == pfa_pkg::STS_ALLOCATED ||
                      rsp_tuser == pfa_pkg::STS_REFUSED))
      else $error("unknown response status");

   // A refusal names no slot and no remainder
   a_refused_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == pfa_pkg::STS_REFUSED) |-> (rsp_tdata[19:0] == 20'd0))
      else $error("refused response carries slot data");

endmodule

bind partition_fit_allocator_core pfa_checker u_pfa_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
